// File: sv/ofmt_pkg.sv
// ofmt_pkg: shared types and constants for the octal number formatter
// no dependencies; imported by every module of the block
package ofmt_pkg;

   localparam int MAX_FIELD  = 64;
   localparam int NUM_DIGITS = 22;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] CSR_FIELD_WIDTH     = 2'd0;
   localparam logic [1:0] CSR_DIGIT_PRECISION = 2'd1;
   localparam logic [1:0] CSR_FORMAT_FLAGS    = 2'd2;

   localparam int FLAG_ALT  = 0;
   localparam int FLAG_LEFT = 1;
   localparam int FLAG_ZPAD = 2;
   localparam int FLAG_PREC = 3;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef struct packed {
      logic [6:0] field_width;
      logic [6:0] digit_precision;
      logic [3:0] format_flags;
   } cfg_type;

   // one formatted item: segment boundaries in character positions
   typedef struct packed {
      logic [63:0] value;
      logic        pad_zero;
      logic [6:0]  lead_end;
      logic [6:0]  prec_end;
      logic [6:0]  dig_end;
      logic [6:0]  total;
   } desc_type;

   typedef struct packed {
      logic not_empty;
      logic not_full;
   } q_status_type;

   function automatic logic [6:0] clamp_field(input logic [6:0] v);
      return (v > 7'(MAX_FIELD)) ? 7'(MAX_FIELD) : v;
   endfunction

endpackage

// File: sv/ofmt_front.sv
// ofmt_front: accepts values, finds the octal digit count and builds a descriptor
// depends on ofmt_pkg
module ofmt_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [63:0]           req_value,
   input  ofmt_pkg::cfg_type     cfg,
   input  ofmt_pkg::q_status_type q_status,
   output logic                  push,
   output ofmt_pkg::desc_type    push_desc
);
   import ofmt_pkg::*;

   logic                  s1_valid_ff, s1_valid_in;
   logic [63:0]           s1_value_ff;
   logic [NUM_DIGITS-1:0] s1_mask_ff, mask_in;
   logic [4:0]            dcount;
   logic                  alt, left, zpad, pgiven;
   logic [6:0]            prec, wid, al, pl, tot, wl, total;
   logic                  accept;

   always_comb begin
      for (int i = 0; i < NUM_DIGITS - 1; i++) begin
         mask_in[i] = |req_value[3*i +: 3];
      end
      mask_in[NUM_DIGITS-1] = req_value[63];
   end

   always_comb begin
      dcount = 5'd0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (s1_mask_ff[i]) begin
            dcount = 5'(i + 1);
         end
      end
   end

   always_comb begin
      alt    = cfg.format_flags[FLAG_ALT];
      left   = cfg.format_flags[FLAG_LEFT];
      zpad   = cfg.format_flags[FLAG_ZPAD];
      pgiven = cfg.format_flags[FLAG_PREC];
      prec   = pgiven ? clamp_field(cfg.digit_precision) : 7'd0;
      wid    = clamp_field(cfg.field_width);
      priority if (dcount == 5'd0 && pgiven && prec == 7'd0) begin
         al = {6'd0, alt};
      end else if (dcount == 5'd0) begin
         al = 7'd1;
      end else begin
         al = {2'd0, dcount} + {6'd0, alt};
      end
      pl    = (prec > al) ? prec - al : 7'd0;
      tot   = al + pl;
      wl    = (wid > tot) ? wid - tot : 7'd0;
      total = tot + wl;
      push_desc.value    = s1_value_ff;
      push_desc.pad_zero = !pgiven && zpad;
      push_desc.lead_end = left ? 7'd0 : wl;
      push_desc.prec_end = push_desc.lead_end + pl;
      push_desc.dig_end  = push_desc.prec_end + al;
      push_desc.total    = total;
   end

   // empty text is dropped without a queue slot
   assign push      = s1_valid_ff && q_status.not_full && (total != 7'd0);
   assign req_stall = s1_valid_ff && !q_status.not_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_valid_ff && q_status.not_full) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_value_ff <= req_value;
         s1_mask_ff  <= mask_in;
      end
   end

endmodule

// File: sv/ofmt_queue.sv
// ofmt_queue: short descriptor queue between front and back
// depends on ofmt_pkg
module ofmt_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ofmt_pkg::desc_type     push_desc,
   input  logic                   pop,
   output ofmt_pkg::desc_type     head,
   output ofmt_pkg::q_status_type status
);
   import ofmt_pkg::*;

   desc_type   entry_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      status.not_empty = (count_ff != 2'd0);
      status.not_full  = (count_ff != 2'(QUEUE_DEPTH));
      head = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// File: sv/ofmt_back.sv
// ofmt_back: walks the head descriptor and emits one character per beat
// depends on ofmt_pkg
module ofmt_back (
   input  logic                   clock,
   input  logic                   reset,
   input  ofmt_pkg::desc_type     head,
   input  ofmt_pkg::q_status_type q_status,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_char,
   output logic                   rsp_last_char
);
   import ofmt_pkg::*;

   logic [6:0]  pos_ff, pos_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  char_ff, char_in;
   logic        last_ff, last_in;
   logic        step;
   logic [6:0]  idx;
   logic [95:0] padded;
   logic [2:0]  digit;

   assign step   = q_status.not_empty && (!rsp_valid_ff || !rsp_stall);
   assign idx    = head.dig_end - 7'd1 - pos_ff;
   assign padded = {32'd0, head.value};
   assign digit  = padded[3*idx[4:0] +: 3];

   always_comb begin
      priority if (pos_ff < head.lead_end) begin
         char_in = head.pad_zero ? CHAR_ZERO : CHAR_SPACE;
      end else if (pos_ff < head.prec_end) begin
         char_in = CHAR_ZERO;
      end else if (pos_ff < head.dig_end) begin
         char_in = CHAR_ZERO + {5'd0, digit};
      end else begin
         char_in = CHAR_SPACE;
      end
      last_in = (pos_ff == head.total - 7'd1);
      pop     = step && last_in;
      pos_in  = pos_ff;
      if (step) begin
         pos_in = last_in ? 7'd0 : pos_ff + 7'd1;
      end
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 7'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         char_ff <= char_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = char_ff;
   assign rsp_last_char = last_ff;

endmodule

// File: sv/octal_number_formatter.sv
// octal_number_formatter: printf style octal text, one character per beat
// path: front stage register, descriptor queue, then character output register
// throughput: one character per cycle while rsp_stall is low; a value gives
// max(width, precision, digit field) characters, 1 to 64; empty text gives none
// reset: synchronous, zeroes the control state and config and empties the descriptor queue
// depends on ofmt_pkg, ofmt_front, ofmt_queue, ofmt_back
module octal_number_formatter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last_char,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_data
);
   import ofmt_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   q_status_type q_status;
   desc_type     push_desc, head;
   logic         push, pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FIELD_WIDTH:     cfg_in.field_width     = csr_data;
            CSR_DIGIT_PRECISION: cfg_in.digit_precision = csr_data;
            CSR_FORMAT_FLAGS:    cfg_in.format_flags    = csr_data[3:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ofmt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_value (req_value),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .push      (push),
      .push_desc (push_desc)
   );

   ofmt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   ofmt_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .q_status      (q_status),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> q_status.not_full)
      else $error("descriptor pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_status.not_empty)
      else $error("descriptor popped from an empty queue");

   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_char == CHAR_SPACE ||
                     (rsp_out_char >= CHAR_ZERO && rsp_out_char <= CHAR_ZERO + 8'd7)))
      else $error("character beat outside digits and space");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("character beat right after reset");

endmodule
